>>> src/llks_pkg.sv
// Shared definitions for the local linear kernel statistic unit.
// Holds the store sizes, command and register codes, sequencer types, the divider
// request and response structs, and the rounding helper. Depends on nothing.
`timescale 1ns / 1ps

package llks_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_BITS   = $clog2(MAX_SAMPLES);

	// Input commands.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_SERIES_LENGTH = 2'd0;
	localparam logic [1:0] REG_SIGMA         = 2'd1;
	localparam logic [1:0] REG_ORDER         = 2'd2;

	// Derivative orders.
	localparam logic [1:0] ORDER_TREND = 2'd0;
	localparam logic [1:0] ORDER_SLOPE = 2'd1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_UT,
		ST_HT,
		ST_RANGE,
		ST_NUM,
		ST_XDIV,
		ST_QQ,
		ST_K,
		ST_KX,
		ST_WRND,
		ST_WY,
		ST_ACC1,
		ST_ACC2,
		ST_A_KX,
		ST_A_XX,
		ST_A_KXX,
		ST_A_ACC,
		ST_B_MUL,
		ST_B_C,
		ST_B_KC,
		ST_NEXT,
		ST_MSTART,
		ST_MWAIT,
		ST_NORM,
		ST_SQRT,
		ST_DMUL,
		ST_CMP,
		ST_FDIV,
		ST_OUT
	} state_t;

	// Which walk over the window is running.
	typedef enum logic [1:0] {
		MODE_INT,
		MODE_P1,
		MODE_P2
	} mode_t;

	typedef struct packed {
		logic        start;
		logic [56:0] rem0;
		logic [30:0] num0;
		logic [56:0] den;
		logic [6:0]  count;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [24:0] quo;
		logic [56:0] rem;
	} div_rsp_t;

	// Round a product to fewer fraction bits, half away from zero.
	function automatic logic signed [58:0] rnd_shift(input logic signed [58:0] v,
		input logic by32);
		logic [58:0] m;
		logic [58:0] r;
		m = v[58] ? 59'(-v) : 59'(v);
		if (by32) begin
			r = (m + 59'h0_8000_0000) >> 32;
		end else begin
			r = (m + 59'h8000) >> 16;
		end
		return v[58] ? $signed(59'(-r)) : $signed(r);
	endfunction

endpackage

>>> src/llks_div.sv
// Shared restoring divider of the kernel statistic unit, one quotient bit per cycle.
// Depends on llks_pkg for the request and response structs.
`timescale 1ns / 1ps

module llks_div (
	input  logic               clk,
	input  logic               arst_n,
	input  llks_pkg::div_req_t req,
	output llks_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [56:0] rem_q;
	logic [30:0] num_q;
	logic [56:0] den_q;
	logic [24:0] quo_q;

	logic [57:0] remx;
	logic [57:0] diff;
	logic        ge;
	logic [24:0] quo_n;

	// One shift and subtract step; the quotient sticks once it reaches the top bit.
	always_comb begin
		remx  = {rem_q, num_q[30]};
		diff  = remx - {1'b0, den_q};
		ge    = remx >= {1'b0, den_q};
		quo_n = quo_q[24] ? quo_q : {quo_q[23:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.count;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem0;
			num_q <= req.num0;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[56:0] : remx[56:0];
			num_q <= {num_q[29:0], 1'b0};
			quo_q <= quo_n;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

>>> src/local_linear_kernel_statistic_unit.sv
// Local linear kernel statistic unit: a load transaction writes one sample into the
// 4096-entry store. A query transaction walks its window of N points with one shared
// multiplier and a shared divider, which runs a 17-step division for each point inside
// the kernel; queries at a boundary walk the window twice and add three 31-step moment
// divisions. The query ends with up to 31 normalizing shifts, a 32-step square root
// and a divide of 32 to 63 steps. The block takes no new transaction until the query
// is finished; the result waits in an output register. The store has no reset and
// must be loaded before it is read. Depends on llks_pkg and llks_div.
`timescale 1ns / 1ps

module local_linear_kernel_statistic_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [11:0]        sample_index,
	input  logic signed [15:0] sample_value,
	input  logic [15:0]        location,
	input  logic [15:0]        bandwidth,
	input  logic [19:0]        correction,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] normalized_average,
	output logic signed [23:0] corrected_value,
	output logic               status
);

	llks_pkg::state_t state_q, state_d;
	llks_pkg::mode_t  mode_q;

	logic [12:0] series_length_q;
	logic [23:0] sigma_q;
	logic [1:0]  order_q;

	logic [15:0] u_q;
	logic [15:0] h_q;
	logic [19:0] c_q;
	logic [28:0] ut_q;
	logic [28:0] d_q;
	logic [12:0] t_q;
	logic [12:0] lo_q;
	logic [12:0] hi_q;
	logic        xneg_q;
	logic [16:0] qm_q;
	logic signed [17:0] x_q;
	logic [15:0] k_q;
	logic signed [19:0] w_q;
	logic signed [19:0] cr_q;
	logic signed [58:0] p_q;
	logic signed [49:0] s_q;
	logic [63:0] wsum_q;
	logic [28:0] a0_q;
	logic signed [29:0] a1_q;
	logic [28:0] a2_q;
	logic [12:0] cnt_q;
	logic [1:0]  mom_q;
	logic signed [17:0] s0_q;
	logic signed [17:0] s1_q;
	logic signed [17:0] s2_q;
	logic [4:0]  sh_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [56:0] den_q;
	logic [24:0] qf_q;
	logic        zero_q;
	logic        out_valid_q;

	logic signed [llks_pkg::SAMPLE_BITS-1:0] store [llks_pkg::MAX_SAMPLES];
	logic signed [llks_pkg::SAMPLE_BITS-1:0] y_q;
	logic [12:0] t_m1;

	logic                 accept;
	logic                 take_out;
	logic [12:0]          t_eff;
	logic [23:0]          sg_eff;
	logic signed [33:0]   mul_a;
	logic signed [24:0]   mul_b;
	logic signed [58:0]   mul_p;
	llks_pkg::div_req_t   div_req;
	llks_pkg::div_rsp_t   div_rsp;

	logic [29:0]        diff_lo;
	logic [30:0]        sum_hi;
	logic [12:0]        lo_c;
	logic [12:0]        hi_c;
	logic               interior;
	logic signed [29:0] num;
	logic [28:0]        m_c;
	logic [17:0]        qround;
	logic [16:0]        qv;
	logic [32:0]        kdiff;
	logic [34:0]        kfull;
	logic signed [58:0] c_c;
	logic [29:0]        amag;
	logic               aneg;
	logic [63:0]        rb;
	logic [49:0]        mag_s;
	logic               neg_s;
	logic [24:0]        qsat;
	logic signed [25:0] v_c;
	logic               last_t;
	llks_pkg::state_t   use_state;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == llks_pkg::ST_IDLE);
	assign take_out = (state_q == llks_pkg::ST_OUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// Effective register values with out-of-range settings folded in.
	assign t_eff = (series_length_q == 13'd0) ? 13'd1 :
		(series_length_q > 13'(llks_pkg::MAX_SAMPLES)) ? 13'(llks_pkg::MAX_SAMPLES) :
		series_length_q;
	assign sg_eff = (sigma_q == 24'd0) ? 24'd1 : sigma_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_length_q <= 13'd4096;
			sigma_q         <= 24'd65536;
			order_q         <= llks_pkg::ORDER_TREND;
		end else if (cfg_we) begin
			case (cfg_index)
				llks_pkg::REG_SERIES_LENGTH: series_length_q <= cfg_data[12:0];
				llks_pkg::REG_SIGMA:         sigma_q <= cfg_data;
				llks_pkg::REG_ORDER:         order_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Sample store with a registered read at the current window point.
	assign t_m1 = t_q - 13'd1;
	always_ff @(posedge clk) begin
		if (accept && cmd == llks_pkg::CMD_LOAD) begin
			store[sample_index] <= llks_pkg::SAMPLE_BITS'(sample_value);
		end
		y_q <= store[t_m1[llks_pkg::ADDR_BITS-1:0]];
	end

	// Shared multiplier; its product is always registered.
	assign mul_p = mul_a * mul_b;

	llks_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Datapath terms used by several states.
	always_comb begin
		diff_lo  = {1'b0, p_q[28:0]};
		diff_lo  = {1'b0, ut_q} - {1'b0, p_q[28:0]};
		sum_hi   = {2'b0, ut_q} + {2'b0, p_q[28:0]} + 31'd65535;
		lo_c     = (u_q > h_q) ? 13'(diff_lo[29:16]) : 13'd0;
		if (lo_c == 13'd0) begin
			lo_c = 13'd1;
		end
		hi_c     = (sum_hi[30:16] > {2'b0, t_eff}) ? t_eff : sum_hi[28:16];
		interior = (u_q > h_q) && (({1'b0, u_q} + {1'b0, h_q}) < 17'h10000);
		num      = $signed({1'b0, t_q, 16'b0}) - $signed({1'b0, ut_q});
		m_c      = num[29] ? 29'(-num) : num[28:0];
		qround   = {1'b0, div_rsp.quo[16:0]} + 18'd1;
		qv       = qround[17:1];
		kdiff    = 33'h1_0000_0000 - p_q[32:0];
		kfull    = 35'd3 * {2'b0, kdiff} + 35'h2_0000;
		if (order_q == llks_pkg::ORDER_SLOPE) begin
			c_c = p_q - $signed({{25{s1_q[17]}}, s1_q, 16'b0});
		end else begin
			c_c = $signed({{25{s2_q[17]}}, s2_q, 16'b0}) - p_q;
		end
		case (mom_q)
			2'd0:    begin amag = {1'b0, a0_q}; aneg = 1'b0; end
			2'd1:    begin amag = a1_q[29] ? 30'(-a1_q) : a1_q; aneg = a1_q[29]; end
			default: begin amag = {1'b0, a2_q}; aneg = 1'b0; end
		endcase
		rb       = r_q + bit_q;
		neg_s    = s_q[49];
		mag_s    = neg_s ? 50'(-s_q) : s_q;
		last_t   = (t_q == hi_q);
		case (mode_q)
			llks_pkg::MODE_INT: use_state = llks_pkg::ST_KX;
			llks_pkg::MODE_P1:  use_state = llks_pkg::ST_A_KX;
			default:            use_state = llks_pkg::ST_B_MUL;
		endcase
		// Final clamp and correction.
		if (neg_s) begin
			qsat = (qf_q > 25'd8388608) ? 25'd8388608 : qf_q;
		end else begin
			qsat = (qf_q > 25'd8388607) ? 25'd8388607 : qf_q;
		end
		v_c = $signed({1'b0, qsat}) - $signed({6'b0, c_q});
		if (v_c > 26'sd8388607) begin
			v_c = 26'sd8388607;
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= llks_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, multiplier operands and divider requests.
	always_comb begin
		state_d       = state_q;
		mul_a         = '0;
		mul_b         = '0;
		div_req       = '0;
		case (state_q)
			llks_pkg::ST_IDLE: begin
				if (accept && cmd == llks_pkg::CMD_QUERY) begin
					state_d = llks_pkg::ST_UT;
				end
			end
			llks_pkg::ST_UT: begin
				mul_a   = $signed({18'b0, u_q});
				mul_b   = $signed({12'b0, t_eff});
				state_d = llks_pkg::ST_HT;
			end
			llks_pkg::ST_HT: begin
				mul_a   = $signed({18'b0, h_q});
				mul_b   = $signed({12'b0, t_eff});
				state_d = llks_pkg::ST_RANGE;
			end
			llks_pkg::ST_RANGE: begin
				if (!interior && order_q > llks_pkg::ORDER_SLOPE) begin
					state_d = llks_pkg::ST_NORM;
				end else begin
					state_d = llks_pkg::ST_NUM;
				end
			end
			llks_pkg::ST_NUM: begin
				if (m_c > d_q) begin
					state_d = use_state;
				end else if (m_c == d_q) begin
					state_d = llks_pkg::ST_QQ;
				end else begin
					div_req.start = 1'b1;
					div_req.rem0  = {28'b0, m_c};
					div_req.den   = {28'b0, d_q};
					div_req.count = 7'd17;
					state_d       = llks_pkg::ST_XDIV;
				end
			end
			llks_pkg::ST_XDIV: begin
				if (div_rsp.done) begin
					state_d = llks_pkg::ST_QQ;
				end
			end
			llks_pkg::ST_QQ: begin
				mul_a   = $signed({17'b0, qm_q});
				mul_b   = $signed({8'b0, qm_q});
				state_d = llks_pkg::ST_K;
			end
			llks_pkg::ST_K: begin
				state_d = use_state;
			end
			llks_pkg::ST_KX, llks_pkg::ST_A_KX: begin
				mul_a   = 34'(x_q);
				mul_b   = $signed({9'b0, k_q});
				state_d = (state_q == llks_pkg::ST_KX) ? llks_pkg::ST_WRND : llks_pkg::ST_A_XX;
			end
			llks_pkg::ST_WRND: begin
				state_d = llks_pkg::ST_WY;
			end
			llks_pkg::ST_WY: begin
				mul_a   = 34'(w_q);
				mul_b   = 25'(y_q);
				state_d = llks_pkg::ST_ACC1;
			end
			llks_pkg::ST_ACC1: begin
				mul_a   = 34'(w_q);
				mul_b   = 25'(w_q);
				state_d = llks_pkg::ST_ACC2;
			end
			llks_pkg::ST_ACC2: begin
				state_d = llks_pkg::ST_NEXT;
			end
			llks_pkg::ST_A_XX: begin
				mul_a   = 34'(x_q);
				mul_b   = 25'(x_q);
				state_d = llks_pkg::ST_A_KXX;
			end
			llks_pkg::ST_A_KXX: begin
				mul_a   = p_q[33:0];
				mul_b   = $signed({9'b0, k_q});
				state_d = llks_pkg::ST_A_ACC;
			end
			llks_pkg::ST_A_ACC: begin
				state_d = llks_pkg::ST_NEXT;
			end
			llks_pkg::ST_B_MUL: begin
				mul_a   = (order_q == llks_pkg::ORDER_SLOPE) ? 34'(s0_q) : 34'(s1_q);
				mul_b   = 25'(x_q);
				state_d = llks_pkg::ST_B_C;
			end
			llks_pkg::ST_B_C: begin
				state_d = llks_pkg::ST_B_KC;
			end
			llks_pkg::ST_B_KC: begin
				mul_a   = 34'(cr_q);
				mul_b   = $signed({9'b0, k_q});
				state_d = llks_pkg::ST_WRND;
			end
			llks_pkg::ST_NEXT: begin
				if (!last_t) begin
					state_d = llks_pkg::ST_NUM;
				end else if (mode_q == llks_pkg::MODE_P1) begin
					state_d = llks_pkg::ST_MSTART;
				end else begin
					state_d = llks_pkg::ST_NORM;
				end
			end
			llks_pkg::ST_MSTART: begin
				div_req.start = 1'b1;
				div_req.num0  = {amag, 1'b0};
				div_req.den   = {44'b0, cnt_q};
				div_req.count = 7'd31;
				state_d       = llks_pkg::ST_MWAIT;
			end
			llks_pkg::ST_MWAIT: begin
				if (div_rsp.done) begin
					state_d = (mom_q == 2'd2) ? llks_pkg::ST_NUM : llks_pkg::ST_MSTART;
				end
			end
			llks_pkg::ST_NORM: begin
				if (wsum_q == 64'd0) begin
					state_d = llks_pkg::ST_OUT;
				end else if (!(sh_q < 5'd31 && wsum_q[63:60] == 4'd0)) begin
					state_d = llks_pkg::ST_SQRT;
				end
			end
			llks_pkg::ST_SQRT: begin
				if (bit_q[0]) begin
					state_d = llks_pkg::ST_DMUL;
				end
			end
			llks_pkg::ST_DMUL: begin
				mul_a   = r_q[33:0];
				mul_b   = $signed({1'b0, sg_eff});
				state_d = llks_pkg::ST_CMP;
			end
			llks_pkg::ST_CMP: begin
				if ({7'b0, mag_s} >= p_q[56:0]) begin
					state_d = llks_pkg::ST_OUT;
				end else begin
					div_req.start = 1'b1;
					div_req.rem0  = {7'b0, mag_s};
					div_req.den   = p_q[56:0];
					div_req.count = 7'd32 + {2'b0, sh_q};
					state_d       = llks_pkg::ST_FDIV;
				end
			end
			llks_pkg::ST_FDIV: begin
				if (div_rsp.done) begin
					state_d = llks_pkg::ST_OUT;
				end
			end
			llks_pkg::ST_OUT: begin
				if (take_out) begin
					state_d = llks_pkg::ST_IDLE;
				end
			end
			default: state_d = llks_pkg::ST_IDLE;
		endcase
	end

	// Walk control: mode, window index, moment counter and zero flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= llks_pkg::MODE_INT;
			t_q    <= 13'd1;
			mom_q  <= 2'd0;
			zero_q <= 1'b0;
		end else begin
			case (state_q)
				llks_pkg::ST_RANGE: begin
					mode_q <= interior ? llks_pkg::MODE_INT : llks_pkg::MODE_P1;
					t_q    <= lo_c;
					mom_q  <= 2'd0;
					zero_q <= 1'b0;
				end
				llks_pkg::ST_NEXT: begin
					if (!last_t) begin
						t_q <= t_q + 13'd1;
					end
				end
				llks_pkg::ST_MWAIT: begin
					if (div_rsp.done) begin
						if (mom_q == 2'd2) begin
							mode_q <= llks_pkg::MODE_P2;
							t_q    <= lo_q;
						end else begin
							mom_q <= mom_q + 2'd1;
						end
					end
				end
				llks_pkg::ST_NORM: begin
					if (wsum_q == 64'd0) begin
						zero_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers of the datapath.
	always_ff @(posedge clk) begin
		p_q <= mul_p;
		if (accept && cmd == llks_pkg::CMD_QUERY) begin
			u_q <= location;
			h_q <= (bandwidth == 16'd0) ? 16'd1 : bandwidth;
			c_q <= correction;
		end
		case (state_q)
			llks_pkg::ST_HT: ut_q <= p_q[28:0];
			llks_pkg::ST_RANGE: begin
				d_q    <= p_q[28:0];
				lo_q   <= lo_c;
				hi_q   <= hi_c;
				s_q    <= '0;
				wsum_q <= '0;
				a0_q   <= '0;
				a1_q   <= '0;
				a2_q   <= '0;
				cnt_q  <= '0;
				sh_q   <= '0;
			end
			llks_pkg::ST_NUM: begin
				xneg_q <= num[29];
				if (m_c > d_q) begin
					x_q <= '0;
					k_q <= '0;
				end else if (m_c == d_q) begin
					qm_q <= 17'h10000;
					x_q  <= num[29] ? -18'sd65536 : 18'sd65536;
				end
			end
			llks_pkg::ST_XDIV: begin
				if (div_rsp.done) begin
					qm_q <= qv;
					x_q  <= xneg_q ? 18'(-$signed({1'b0, qv})) : $signed({1'b0, qv});
				end
			end
			llks_pkg::ST_K: k_q <= kfull[33:18];
			llks_pkg::ST_WRND: w_q <= 20'(llks_pkg::rnd_shift(p_q, 1'b0));
			llks_pkg::ST_ACC1: s_q <= s_q + p_q[49:0];
			llks_pkg::ST_ACC2: wsum_q <= wsum_q + {24'b0, p_q[39:0]};
			llks_pkg::ST_A_KX: a0_q <= a0_q + {13'b0, k_q};
			llks_pkg::ST_A_XX: a1_q <= a1_q + 30'(llks_pkg::rnd_shift(p_q, 1'b0));
			llks_pkg::ST_A_ACC: begin
				a2_q  <= a2_q + 29'(llks_pkg::rnd_shift(p_q, 1'b1));
				cnt_q <= cnt_q + 13'd1;
			end
			llks_pkg::ST_B_C: cr_q <= 20'(llks_pkg::rnd_shift(c_c, 1'b0));
			llks_pkg::ST_MWAIT: begin
				if (div_rsp.done) begin
					case (mom_q)
						2'd0:    s0_q <= $signed({1'b0, qv});
						2'd1:    s1_q <= aneg ? 18'(-$signed({1'b0, qv})) : $signed({1'b0, qv});
						default: s2_q <= $signed({1'b0, qv});
					endcase
				end
			end
			llks_pkg::ST_NORM: begin
				if (sh_q < 5'd31 && wsum_q[63:60] == 4'd0) begin
					wsum_q <= {wsum_q[61:0], 2'b00};
					sh_q   <= sh_q + 5'd1;
				end
				r_q   <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			llks_pkg::ST_SQRT: begin
				// One step of the bitwise floor square root.
				if (wsum_q >= rb) begin
					wsum_q <= wsum_q - rb;
					r_q    <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			llks_pkg::ST_CMP: begin
				den_q <= p_q[56:0];
				qf_q  <= 25'h100_0000;
			end
			llks_pkg::ST_FDIV: begin
				if (div_rsp.done) begin
					if (!div_rsp.quo[24] && {div_rsp.rem, 1'b0} >= {1'b0, den_q}) begin
						qf_q <= div_rsp.quo + 25'd1;
					end else begin
						qf_q <= div_rsp.quo;
					end
				end
			end
			default: ;
		endcase
	end

	// Output register; a result waits here until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_out) begin
			if (zero_q) begin
				normalized_average <= '0;
				corrected_value    <= '0;
				status             <= 1'b1;
			end else begin
				normalized_average <= neg_s ? 24'(-$signed({1'b0, qsat})) : qsat[23:0];
				corrected_value    <= v_c[23:0];
				status             <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// A zero weight norm forces both values to zero.
	a_zero_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> normalized_average == 24'sd0 && corrected_value == 24'sd0)
		else $error("status set with nonzero result");

	// The divider only finishes while the sequencer waits for it.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == llks_pkg::ST_XDIV || state_q == llks_pkg::ST_MWAIT
			|| state_q == llks_pkg::ST_FDIV)
		else $error("divider finished outside a wait state");

	// The window index stays inside its bounds while points are processed.
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == llks_pkg::ST_NUM |-> t_q >= lo_q && t_q <= hi_q)
		else $error("window index out of range");

	// Subtracting the correction never raises a positive average.
	a_corr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !normalized_average[23] |-> corrected_value <= normalized_average)
		else $error("corrected value above the average");
`endif

endmodule
